### rtl/hcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcl_pkg
// Shared defaults and codes for the Huffman code length builder.
// ----------------------------------------------------------------------------
package hcl_pkg;

  localparam int MAX_SYMBOLS_DEF = 256;
  localparam int WEIGHT_BITS_DEF = 32;

  localparam int SYM_W = 8;
  localparam int LEN_W = 8;
  localparam int WEIGHT_IN_W = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

endpackage
`default_nettype wire

### rtl/huffman_code_length_builder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_code_length_builder
// Loads weighted byte symbols, builds a Huffman tree with one shared compare
// and add unit, and returns code lengths sorted by length then symbol.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in_     | input     | in_valid, in_stall, in_op, in_symbol, in_weight,
//          |           | in_last_symbol
//  out_    | output    | out_valid, out_stall, out_valid_res, out_out_symbol,
//          |           | out_code_length, out_last_result
//
//  A load stores one weighted symbol unless MAX_SYMBOLS are already held; a
//  fetch makes one read of the sorted result RAM, or, when nothing is pending,
//  returns a word with out_valid_res low. A build runs a min scan over the node
//  RAM for each of the n-1 merges, then a depth pass over the nodes from the
//  root down, with an insertion sort of each leaf that shifts sorted entries.
//  The input stalls while a build or fetch runs and while a word is held.
//  Reset is synchronous; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module huffman_code_length_builder #(
  parameter int MAX_SYMBOLS = hcl_pkg::MAX_SYMBOLS_DEF,
  parameter int WEIGHT_BITS = hcl_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic                          in_op,
  input  wire logic [hcl_pkg::SYM_W-1:0]     in_symbol,
  input  wire logic [hcl_pkg::WEIGHT_IN_W-1:0] in_weight,
  input  wire logic                          in_last_symbol,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic                          out_valid_res,
  output      logic [hcl_pkg::SYM_W-1:0]     out_out_symbol,
  output      logic [hcl_pkg::LEN_W-1:0]     out_code_length,
  output      logic                          out_last_result
);
  import hcl_pkg::*;

  localparam int NODES  = 2 * MAX_SYMBOLS - 1;
  localparam int IW     = $clog2(NODES);
  localparam int CW     = $clog2(MAX_SYMBOLS + 1);
  localparam int SW     = $clog2(MAX_SYMBOLS);
  localparam int NW     = WEIGHT_BITS + SW;
  localparam int NODE_W = 1 + NW + IW;
  localparam int KEY_W  = LEN_W + SYM_W;
  localparam int WIN_W  = (WEIGHT_BITS < WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_SCAN  = 14'b00000000000010,
    S_MRG_A = 14'b00000000000100,
    S_MRG_B = 14'b00000000001000,
    S_MRG_P = 14'b00000000010000,
    S_D_ST  = 14'b00000000100000,
    S_D_PAR = 14'b00000001000000,
    S_D_PWT = 14'b00000010000000,
    S_D_DEP = 14'b00000100000000,
    S_LEAF  = 14'b00001000000000,
    S_INS_R = 14'b00010000000000,
    S_INS_C = 14'b00100000000000,
    S_K_NXT = 14'b01000000000000,
    S_FETCH = 14'b10000000000000
  } state_t;

  logic [NODE_W-1:0] node_mem [NODES];
  logic [LEN_W-1:0]  dep_mem  [NODES];
  logic [SYM_W-1:0]  sym_mem  [MAX_SYMBOLS];
  logic [KEY_W-1:0]  srt_mem  [MAX_SYMBOLS];

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, emit_r, emit_nxt, n_r, n_nxt;
  logic [CW-1:0] alive_r, alive_nxt, ins_n_r, ins_n_nxt, j_r, j_nxt;
  logic emitting_r, emitting_nxt;
  logic [IW-1:0] total_r, total_nxt, scan_i_r, scan_i_nxt, k_r, k_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt, a_idx_r, a_idx_nxt, b_idx_r, b_idx_nxt;
  logic [NW-1:0] a_w_r, a_w_nxt, b_w_r, b_w_nxt;
  logic a_ok_r, a_ok_nxt, b_ok_r, b_ok_nxt, rd_pend_r, rd_pend_nxt;
  logic [LEN_W-1:0] d_r, d_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic out_valid_r, out_valid_nxt, res_r, res_nxt, fin_r, fin_nxt;
  logic [SYM_W-1:0] osym_r, osym_nxt;
  logic [LEN_W-1:0] olen_r, olen_nxt;

  logic [NODE_W-1:0] node_q_r, node_wdata;
  logic [IW-1:0] node_waddr, node_raddr, dep_waddr, dep_raddr, tm1;
  logic node_we, dep_we, sym_we, srt_we;
  logic [LEN_W-1:0] dep_q_r, dep_wdata;
  logic [SYM_W-1:0] sym_q_r;
  logic [SW-1:0] sym_waddr, sym_raddr, srt_waddr, srt_raddr;
  logic [KEY_W-1:0] srt_q_r, srt_wdata;
  logic q_live;
  logic [NW-1:0] q_w;
  logic [IW-1:0] q_par;
  logic in_acc, out_acc;

  assign q_live   = node_q_r[NODE_W-1];
  assign q_w      = node_q_r[NW+IW-1:IW];
  assign q_par    = node_q_r[IW-1:0];
  assign tm1      = total_r - 1'b1;
  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;

  assign out_valid       = out_valid_r;
  assign out_valid_res   = res_r;
  assign out_out_symbol  = osym_r;
  assign out_code_length = olen_r;
  assign out_last_result = fin_r;

  always_comb begin
    logic [CW-1:0] c;
    c = '0;
    state_nxt = state_r;  count_nxt = count_r;  emit_nxt = emit_r;  n_nxt = n_r;
    alive_nxt = alive_r;  ins_n_nxt = ins_n_r;  j_nxt = j_r;  emitting_nxt = emitting_r;
    total_nxt = total_r;  scan_i_nxt = scan_i_r;  k_nxt = k_r;  rd_idx_nxt = rd_idx_r;
    a_idx_nxt = a_idx_r;  b_idx_nxt = b_idx_r;  a_w_nxt = a_w_r;  b_w_nxt = b_w_r;
    a_ok_nxt = a_ok_r;  b_ok_nxt = b_ok_r;  rd_pend_nxt = rd_pend_r;  d_nxt = d_r;
    key_nxt = key_r;  out_valid_nxt = out_valid_r;  res_nxt = res_r;  fin_nxt = fin_r;
    osym_nxt = osym_r;  olen_nxt = olen_r;
    node_we = 1'b0;  node_waddr = k_r;  node_wdata = '0;  node_raddr = k_r;
    dep_we = 1'b0;  dep_waddr = k_r;  dep_wdata = '0;  dep_raddr = q_par;
    sym_we = 1'b0;  sym_waddr = '0;  sym_raddr = k_r[SW-1:0];
    srt_we = 1'b0;  srt_waddr = j_r[SW-1:0];  srt_wdata = key_r;
    srt_raddr = emit_r[SW-1:0];
    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_LOAD) begin
            c = emitting_r ? '0 : count_r;
            emitting_nxt = 1'b0;
            emit_nxt = '0;
            if (c < CW'(MAX_SYMBOLS)) begin
              node_we = 1'b1;
              node_waddr = IW'(c);
              node_wdata = {1'b1, NW'(in_weight[WIN_W-1:0]), {IW{1'b0}}};
              sym_we = 1'b1;
              sym_waddr = c[SW-1:0];
              c = c + 1'b1;
            end
            count_nxt = c;
            if (in_last_symbol) begin
              n_nxt = c;
              total_nxt = IW'(c);
              alive_nxt = c;
              ins_n_nxt = '0;
              scan_i_nxt = '0;
              rd_pend_nxt = 1'b0;
              a_ok_nxt = 1'b0;
              b_ok_nxt = 1'b0;
              state_nxt = (c > CW'(1)) ? S_SCAN : S_D_ST;
            end
          end else if (emitting_r && (emit_r < count_r)) begin
            state_nxt = S_FETCH;
          end else begin
            out_valid_nxt = 1'b1;
            res_nxt = 1'b0;
            osym_nxt = '0;
            olen_nxt = '0;
            fin_nxt = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (rd_pend_r && q_live) begin
          if (!a_ok_r || (q_w < a_w_r)) begin
            b_ok_nxt = a_ok_r;
            b_idx_nxt = a_idx_r;
            b_w_nxt = a_w_r;
            a_ok_nxt = 1'b1;
            a_idx_nxt = rd_idx_r;
            a_w_nxt = q_w;
          end else if (!b_ok_r || (q_w < b_w_r)) begin
            b_ok_nxt = 1'b1;
            b_idx_nxt = rd_idx_r;
            b_w_nxt = q_w;
          end
        end
        if (scan_i_r < total_r) begin
          node_raddr = scan_i_r;
          rd_idx_nxt = scan_i_r;
          rd_pend_nxt = 1'b1;
          scan_i_nxt = scan_i_r + 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
        end
        if (!rd_pend_r && (scan_i_r == total_r)) begin
          state_nxt = S_MRG_A;
        end
      end
      S_MRG_A: begin
        node_we = 1'b1;
        node_waddr = a_idx_r;
        node_wdata = {1'b0, a_w_r, total_r};
        state_nxt = S_MRG_B;
      end
      S_MRG_B: begin
        node_we = 1'b1;
        node_waddr = b_idx_r;
        node_wdata = {1'b0, b_w_r, total_r};
        state_nxt = S_MRG_P;
      end
      S_MRG_P: begin
        node_we = 1'b1;
        node_waddr = total_r;
        node_wdata = {1'b1, a_w_r + b_w_r, {IW{1'b0}}};
        total_nxt = total_r + 1'b1;
        alive_nxt = alive_r - 1'b1;
        scan_i_nxt = '0;
        rd_pend_nxt = 1'b0;
        a_ok_nxt = 1'b0;
        b_ok_nxt = 1'b0;
        state_nxt = (alive_r > CW'(2)) ? S_SCAN : S_D_ST;
      end
      S_D_ST: begin
        dep_we = 1'b1;
        dep_waddr = tm1;
        dep_wdata = '0;
        k_nxt = tm1;
        d_nxt = '0;
        sym_raddr = tm1[SW-1:0];
        state_nxt = S_LEAF;
      end
      S_D_PAR: begin
        state_nxt = S_D_PWT;
      end
      S_D_PWT: begin
        state_nxt = S_D_DEP;
      end
      S_D_DEP: begin
        d_nxt = dep_q_r + 1'b1;
        dep_we = 1'b1;
        dep_wdata = dep_q_r + 1'b1;
        state_nxt = S_LEAF;
      end
      S_LEAF: begin
        if (k_r < IW'(n_r)) begin
          key_nxt = {d_r, sym_q_r};
          j_nxt = ins_n_r;
          state_nxt = S_INS_R;
        end else begin
          state_nxt = S_K_NXT;
        end
      end
      S_INS_R: begin
        if (j_r == '0) begin
          srt_we = 1'b1;
          ins_n_nxt = ins_n_r + 1'b1;
          state_nxt = S_K_NXT;
        end else begin
          srt_raddr = SW'(j_r - 1'b1);
          state_nxt = S_INS_C;
        end
      end
      S_INS_C: begin
        srt_we = 1'b1;
        if (srt_q_r > key_r) begin
          srt_wdata = srt_q_r;
          j_nxt = j_r - 1'b1;
          state_nxt = S_INS_R;
        end else begin
          ins_n_nxt = ins_n_r + 1'b1;
          state_nxt = S_K_NXT;
        end
      end
      S_K_NXT: begin
        if (k_r == '0) begin
          emitting_nxt = 1'b1;
          emit_nxt = '0;
          count_nxt = n_r;
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r - 1'b1;
          state_nxt = S_D_PAR;
        end
      end
      S_FETCH: begin
        out_valid_nxt = 1'b1;
        res_nxt = 1'b1;
        osym_nxt = srt_q_r[SYM_W-1:0];
        olen_nxt = srt_q_r[KEY_W-1:SYM_W];
        fin_nxt = ((emit_r + 1'b1) == count_r);
        if ((emit_r + 1'b1) == count_r) begin
          emitting_nxt = 1'b0;
          count_nxt = '0;
          emit_nxt = '0;
        end else begin
          emit_nxt = emit_r + 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_q_r <= node_mem[node_raddr];
    if (dep_we) begin
      dep_mem[dep_waddr] <= dep_wdata;
    end
    dep_q_r <= dep_mem[dep_raddr];
    if (sym_we) begin
      sym_mem[sym_waddr] <= in_symbol;
    end
    sym_q_r <= sym_mem[sym_raddr];
    if (srt_we) begin
      srt_mem[srt_waddr] <= srt_wdata;
    end
    srt_q_r <= srt_mem[srt_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      emit_r <= '0;
      emitting_r <= 1'b0;
      out_valid_r <= 1'b0;
      ins_n_r <= '0;
      n_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      emit_r <= emit_nxt;
      emitting_r <= emitting_nxt;
      out_valid_r <= out_valid_nxt;
      ins_n_r <= ins_n_nxt;
      n_r <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    alive_r <= alive_nxt;  j_r <= j_nxt;  total_r <= total_nxt;  scan_i_r <= scan_i_nxt;
    k_r <= k_nxt;  rd_idx_r <= rd_idx_nxt;  a_idx_r <= a_idx_nxt;  b_idx_r <= b_idx_nxt;
    a_w_r <= a_w_nxt;  b_w_r <= b_w_nxt;  a_ok_r <= a_ok_nxt;  b_ok_r <= b_ok_nxt;
    rd_pend_r <= rd_pend_nxt;  d_r <= d_nxt;  key_r <= key_nxt;  res_r <= res_nxt;
    fin_r <= fin_nxt;  osym_r <= osym_nxt;  olen_r <= olen_nxt;
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> state_r == S_IDLE)
    else $error("input word taken while busy");

  a_scan_alive: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> alive_r > CW'(1))
    else $error("merge scan with fewer than two live nodes");

  a_ins_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ins_n_r <= n_r)
    else $error("sorted entries exceed symbol count");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emitting_r |-> emit_r < count_r)
    else $error("emit pointer past last result");

endmodule
`default_nettype wire
